FILE: hw/rtl/trie_word_translation_map_defines.svh
// Assertion macros for the trie word translation map.
`ifndef TRIE_WORD_TRANSLATION_MAP_DEFINES_SVH
`define TRIE_WORD_TRANSLATION_MAP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define TWTM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence starting in the cycle after its cause.
`define TWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

FILE: hw/rtl/twtm_pkg.sv
// Shared types and constants for the trie word translation map.
`default_nettype none

package twtm_pkg;

    localparam int LETTER_W = 5;
    localparam int VALUE_W  = 50;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_END
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
        logic item_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/trie_word_translation_map.sv
// Top level of the trie word translation map.
//
//   Channel   Direction   Handshake           Payload
//   input     in          i_valid / o_stall   i_cmd, i_letter, i_last, i_value
//   result    out         o_valid / i_stall   o_status, o_result_value
//
// A letter that is not the last of its word goes through a child-table read,
// then the walk decision with any node allocation.
// A last letter then gets a result step from the word mark and stored value.
// After reset the child table and word marks are swept once, one entry a cycle,
// over NODE_COUNT * ALPHABET_SIZE entries (26624 by default), o_stall high.
// A result waits in the output register while i_stall is high; the next
// letter is still taken, and only a following last letter waits for the slot.
`default_nettype none

module trie_word_translation_map #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int VALUE_CHARS   = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_cmd,
    input  wire logic [twtm_pkg::LETTER_W-1:0] i_letter,
    input  wire logic                          i_last,
    input  wire logic [twtm_pkg::VALUE_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [twtm_pkg::STATUS_W-1:0]      o_status,
    output logic [twtm_pkg::VALUE_W-1:0]       o_result_value
);
    import twtm_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    twtm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (ctrl_stat),
        .o_cmd   (ctrl_cmd)
    );

    twtm_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .VALUE_CHARS   (VALUE_CHARS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_stat         (ctrl_stat),
        .i_item_cmd     (i_cmd),
        .i_letter       (i_letter),
        .i_last         (i_last),
        .i_value        (i_value),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/twtm_ctrl.sv
// Sequencer for clearing, letter steps and word completion.
`default_nettype none

module twtm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire twtm_pkg::t_ctrl_stat i_stat,
    output twtm_pkg::t_ctrl_cmd       o_cmd
);
    import twtm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_STEP;
            end
            S_STEP: begin
                n_state = i_stat.item_last ? S_END : S_IDLE;
            end
            S_END: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
            end
            S_END: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/twtm_datapath.sv
// Trie memories, walk registers and result register.
`default_nettype none

module twtm_datapath #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int VALUE_CHARS   = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire twtm_pkg::t_ctrl_cmd              i_cmd,
    output twtm_pkg::t_ctrl_stat                  o_stat,
    input  wire logic                             i_item_cmd,
    input  wire logic [twtm_pkg::LETTER_W-1:0]    i_letter,
    input  wire logic                             i_last,
    input  wire logic [twtm_pkg::VALUE_W-1:0]     i_value,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output logic [twtm_pkg::STATUS_W-1:0]         o_status,
    output logic [twtm_pkg::VALUE_W-1:0]          o_result_value
);
    import twtm_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int FW    = $clog2(NODE_COUNT + 1);
    localparam int SLOTS = NODE_COUNT * ALPHABET_SIZE;
    localparam int SW    = $clog2(SLOTS);
    localparam int AW    = $clog2(ALPHABET_SIZE + 1);
    localparam int CW    = (AW > LETTER_W) ? AW : LETTER_W;
    localparam int VB    = (5 * VALUE_CHARS < VALUE_W) ? 5 * VALUE_CHARS : VALUE_W;

    logic [NW-1:0] child_table [SLOTS];
    logic          word_marks  [NODE_COUNT];
    logic [VB-1:0] value_store [NODE_COUNT];

    logic [SW-1:0]       r_clr;
    logic [NW-1:0]       r_cursor;
    logic                r_miss;
    logic                r_ovf;
    logic [FW-1:0]       r_next_free;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [VALUE_W-1:0]  r_result;

    logic          r_cmd;
    logic          r_letter_ok;
    logic          r_last;
    logic [VB-1:0] r_value;
    logic [SW-1:0] r_slot;
    logic [NW-1:0] r_child;
    logic          r_mark_q;
    logic [VB-1:0] r_val_q;

    logic                letter_ok;
    logic [SW-1:0]       rd_slot;
    logic [NW-1:0]       n_cursor;
    logic                n_miss;
    logic                n_ovf;
    logic                alloc;
    logic                mark_set;
    logic                clr_mark;
    logic [STATUS_W-1:0] n_status;
    logic [VALUE_W-1:0]  n_result;
    logic                out_free;

    assign letter_ok = CW'(i_letter) < CW'(ALPHABET_SIZE);
    assign rd_slot   = SW'(SW'(r_cursor) * SW'(ALPHABET_SIZE)) + SW'(i_letter);
    assign clr_mark  = r_clr < SW'(NODE_COUNT);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_cursor = r_cursor;
        n_miss   = r_miss;
        n_ovf    = r_ovf;
        alloc    = 1'b0;
        if (r_letter_ok) begin
            if (r_cmd == CMD_INSERT) begin
                if (!r_ovf) begin
                    if (r_child == '0) begin
                        if (r_next_free < FW'(NODE_COUNT)) begin
                            alloc    = 1'b1;
                            n_cursor = r_next_free[NW-1:0];
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_cursor = r_child;
                    end
                end
            end else begin
                if (!r_miss) begin
                    if (r_child == '0) begin
                        n_miss = 1'b1;
                    end else begin
                        n_cursor = r_child;
                    end
                end
            end
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_result = '0;
        mark_set = 1'b0;
        if (r_cmd == CMD_INSERT) begin
            if (r_ovf) begin
                n_status = ST_FULL;
            end else begin
                mark_set = i_cmd.finish && (r_cursor != '0);
            end
        end else begin
            if (!r_miss && (r_cursor != '0) && r_mark_q) begin
                n_result = VALUE_W'(r_val_q);
            end else begin
                n_status = ST_MISS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_cursor    <= '0;
            r_miss      <= 1'b0;
            r_ovf       <= 1'b0;
            r_next_free <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + SW'(1);
            end
            if (i_cmd.step) begin
                r_cursor <= n_cursor;
                r_miss   <= n_miss;
                r_ovf    <= n_ovf;
                if (alloc) r_next_free <= r_next_free + FW'(1);
            end else if (i_cmd.finish) begin
                r_cursor <= '0;
                r_miss   <= 1'b0;
                r_ovf    <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd       <= i_item_cmd;
            r_letter_ok <= letter_ok;
            r_last      <= i_last;
            r_value     <= i_value[VB-1:0];
            r_slot      <= rd_slot;
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            child_table[r_clr] <= '0;
        end else if (i_cmd.step && alloc) begin
            child_table[r_slot] <= r_next_free[NW-1:0];
        end
        if (i_cmd.accept && letter_ok) begin
            r_child <= child_table[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear && clr_mark) begin
            word_marks[r_clr[NW-1:0]] <= 1'b0;
        end else if (i_cmd.step && alloc) begin
            word_marks[r_next_free[NW-1:0]] <= 1'b0;
        end else if (mark_set) begin
            word_marks[r_cursor] <= 1'b1;
        end
        if (i_cmd.step) begin
            r_mark_q <= alloc ? 1'b0 : word_marks[n_cursor];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_set) begin
            value_store[r_cursor] <= r_value;
        end
        if (i_cmd.step) begin
            r_val_q <= value_store[n_cursor];
        end
    end

    assign o_stat.clear_last = r_clr == SW'(SLOTS - 1);
    assign o_stat.item_last  = r_last;
    assign o_stat.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;

endmodule

`default_nettype wire

FILE: hw/rtl/twtm_checker.sv
// Port-level checks for the trie word translation map and their binding.
`default_nettype none

`include "trie_word_translation_map_defines.svh"

module twtm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          i_last,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [twtm_pkg::STATUS_W-1:0] o_status,
    input wire logic [twtm_pkg::VALUE_W-1:0]  o_result_value
);
    import twtm_pkg::*;

    logic in_acc;

    assign in_acc = i_valid && !o_stall;

    `TWTM_ASSERT_SAME(a_value_only_on_hit, i_clk, i_rst_n, o_valid && (o_status != ST_OK) && (o_status != ST_MISS), o_result_value == '0, "result value set without a search hit")
    `TWTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall, "item taken while previous item still walking")
    `TWTM_ASSERT_NEXT(a_no_result_mid_word, i_clk, i_rst_n, in_acc && !i_last, !$rose(o_valid), "result raised for a letter that is not last")
    `TWTM_ASSERT_NEXT(a_result_after_last, i_clk, i_rst_n, in_acc && i_last && !o_valid, ##2 o_valid, "last letter gave no result in time")
    `TWTM_ASSERT_NEXT(a_hold_stalled_result, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_result_value),
        "stalled result item changed")

endmodule

bind trie_word_translation_map twtm_checker u_twtm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_result_value (o_result_value)
);

`default_nettype wire
